>>> sv/hdlcr_pkg.sv
`timescale 1ns / 1ps

package hdlcr_pkg;

    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [7:0]  ESC_BYTE    = 8'h7D;
    localparam logic [7:0]  ESC_MASK    = 8'h20;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_RESIDUE = 16'hF0B8;
    localparam logic [15:0] CRC_POLY    = 16'h8408;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_ABORT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic [7:0] frame_length;
    } t_result;

    // reflected CRC-16/X.25, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> sv/hdlcr_if.sv
`timescale 1ns / 1ps

interface hdlcr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hdlcr_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] frame_length;

    modport source (output valid, output kind, output data_byte, output frame_length,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input frame_length,
                    output ready);
endinterface

interface hdlcr_cfg_if;
    logic valid;
    logic ready;
    logic receive_enable;

    modport source (output valid, output receive_enable, input ready);
    modport sink   (input valid, input receive_enable, output ready);
endinterface

>>> sv/hdlcr_deframer.sv
`timescale 1ns / 1ps

module hdlcr_deframer #(
    parameter int MAX_FRAME_BYTES = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_enable,
    input  logic                i_advance,
    output logic                o_res_valid,
    output hdlcr_pkg::t_result  o_res
);
    import hdlcr_pkg::*;

    localparam logic [7:0] MAX_COUNT = 8'(MAX_FRAME_BYTES);

    logic        r_receiving,  n_receiving;
    logic        r_last_flag,  n_last_flag;
    logic        r_escape,     n_escape;
    logic [7:0]  r_count,      n_count;
    logic [15:0] r_crc,        n_crc;
    logic [7:0]  r_hold_older, n_hold_older;
    logic [7:0]  r_hold_newer, n_hold_newer;

    logic        is_flag, is_esc, start, take, close, stream;
    logic [7:0]  base_count, inc_count, ub;
    logic [15:0] base_crc;

    always_comb begin
        is_flag    = (i_byte == FLAG_BYTE);
        is_esc     = (i_byte == ESC_BYTE);
        start      = !r_receiving && r_last_flag && !is_flag;
        take       = start || (r_receiving && !is_flag);
        close      = r_receiving && is_flag;
        base_count = start ? 8'd0 : r_count;
        base_crc   = start ? CRC_INIT : r_crc;
        ub         = r_escape ? (i_byte ^ ESC_MASK) : i_byte;
        stream     = (base_count >= 8'd2);
        inc_count  = base_count + 8'd1;
    end

    always_comb begin
        n_receiving  = r_receiving;
        n_last_flag  = r_last_flag;
        n_escape     = r_escape;
        n_count      = r_count;
        n_crc        = r_crc;
        n_hold_older = r_hold_older;
        n_hold_newer = r_hold_newer;
        o_res_valid  = 1'b0;
        o_res        = '{kind: KIND_DATA, data_byte: 8'd0, frame_length: 8'd0};
        if (i_valid && i_enable) begin
            n_last_flag = is_flag;
            if (take && is_esc) begin
                n_escape    = 1'b1;
                n_receiving = 1'b1;
                n_count     = base_count;
                n_crc       = base_crc;
            end else if (take) begin
                n_escape     = 1'b0;
                n_crc        = crc_byte(base_crc, ub);
                n_hold_older = r_hold_newer;
                n_hold_newer = ub;
                if (inc_count >= MAX_COUNT) begin
                    n_receiving = 1'b0;
                    n_count     = 8'd0;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_ABORT;
                end else begin
                    n_receiving = 1'b1;
                    n_count     = inc_count;
                    if (stream) begin
                        o_res_valid     = 1'b1;
                        o_res.data_byte = r_hold_older;
                    end
                end
            end else if (close) begin
                n_receiving        = 1'b0;
                n_count            = 8'd0;
                o_res_valid        = 1'b1;
                o_res.frame_length = (r_count >= 8'd2) ? r_count - 8'd2 : 8'd0;
                o_res.kind         = ((r_count >= 8'd2) && (r_crc == CRC_RESIDUE))
                                     ? KIND_GOOD : KIND_BAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving  <= 1'b0;
            r_last_flag  <= 1'b1;
            r_escape     <= 1'b0;
            r_count      <= 8'd0;
            r_crc        <= CRC_INIT;
            r_hold_older <= 8'd0;
            r_hold_newer <= 8'd0;
        end else if (i_advance) begin
            r_receiving  <= n_receiving;
            r_last_flag  <= n_last_flag;
            r_escape     <= n_escape;
            r_count      <= n_count;
            r_crc        <= n_crc;
            r_hold_older <= n_hold_older;
            r_hold_newer <= n_hold_newer;
        end
    end

endmodule

>>> sv/hdlcr_out_reg.sv
`timescale 1ns / 1ps

module hdlcr_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hdlcr_pkg::t_result i_res,
    output logic               o_can_take,
    hdlcr_res_if.source        o_res
);
    import hdlcr_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_take = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_res.kind;
    assign o_res.data_byte    = r_res.data_byte;
    assign o_res.frame_length = r_res.frame_length;

endmodule

>>> sv/hdlc_frame_receiver.sv
`timescale 1ns / 1ps

// channel   dir  payload                          request moves
// i_rx      in   rx_byte[7:0]                     one raw line byte
// o_res     out  kind[1:0] data_byte frame_length zero or one result per byte
// i_cfg     in   receive_enable                   enable register write
//
// One byte per cycle sustained while results are taken; a result passes from
// the input register, which captures its byte when it is taken, to the result
// register. CRC and unescape are combinational between the two. Reset is
// synchronous, active low, and clears all frame state. A stalled result holds
// the result register and, through it, the input register; ready falls only
// while both are full.

module hdlc_frame_receiver #(
    parameter int MAX_FRAME_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hdlcr_rx_if.sink    i_rx,
    hdlcr_res_if.source o_res,
    hdlcr_cfg_if.sink   i_cfg
);
    import hdlcr_pkg::*;

    logic       r_enable;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       can_take;
    logic       res_valid;
    t_result    res;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = !r_in_valid || can_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg.valid) begin
            r_enable <= i_cfg.receive_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    hdlcr_deframer #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_byte      (r_in_byte),
        .i_enable    (r_enable),
        .i_advance   (can_take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hdlcr_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (res_valid),
        .i_res      (res),
        .o_can_take (can_take),
        .o_res      (o_res)
    );

endmodule

>>> dv/tb_hdlc_frame_receiver.sv
`timescale 1ns / 1ps

module tb_hdlc_frame_receiver;
    import hdlcr_pkg::*;

    localparam int FRAME_LIMIT = 128;

    typedef struct {
        logic [7:0] raw;
        bit         typed;
        t_result    want;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    hdlcr_rx_if  rx_ch ();
    hdlcr_res_if res_ch ();
    hdlcr_cfg_if cfg_ch ();

    hdlc_frame_receiver #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_rx   (rx_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    // deframer state as seen by the predictor
    logic        en_reg     = 1'b0;
    logic        in_frame   = 1'b0;
    logic        after_flag = 1'b1;
    logic        esc_armed  = 1'b0;
    logic [7:0]  nbytes     = 8'd0;
    logic [15:0] crc_acc    = CRC_INIT;
    logic [7:0]  hist_old   = 8'd0;
    logic [7:0]  hist_new   = 8'd0;

    t_result  pending_results[$];
    t_dir_row dir_rows[$];
    int       fail_count = 0;
    int       items_sent = 0;
    int       frame_no   = 0;
    bit       calm       = 1'b0;
    bit       hold_ask   = 1'b0;
    bit       hold_done  = 1'b0;
    int       hold_left  = 0;

    function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] v;
        v = acc ^ {8'h00, b};
        repeat (8) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    function automatic bit absorb_byte(input logic [7:0] raw, inout t_result r);
        logic [7:0] b;
        bit         send;
        bit         got;
        got = 1'b0;
        if (raw == ESC_BYTE) begin
            esc_armed = 1'b1;
            return 1'b0;
        end
        b = esc_armed ? (raw ^ ESC_MASK) : raw;
        esc_armed = 1'b0;
        send = (nbytes >= 8'd2);
        crc_acc = fcs_update(crc_acc, b);
        nbytes = nbytes + 8'd1;
        if (int'(nbytes) >= FRAME_LIMIT) begin
            in_frame = 1'b0;
            nbytes = 8'd0;
            r.kind = KIND_ABORT;
            got = 1'b1;
        end else if (send) begin
            r.kind = KIND_DATA;
            r.data_byte = hist_old;
            got = 1'b1;
        end
        hist_old = hist_new;
        hist_new = b;
        return got;
    endfunction

    function automatic bit predict_byte(input logic [7:0] raw, output t_result r);
        bit is_flag;
        bit got;
        r = '0;
        got = 1'b0;
        if (!en_reg) begin
            return 1'b0;
        end
        is_flag = (raw == FLAG_BYTE);
        if (!in_frame && after_flag && !is_flag) begin
            in_frame = 1'b1;
            nbytes = 8'd0;
            crc_acc = CRC_INIT;
            got = absorb_byte(raw, r);
        end else if (in_frame && !is_flag) begin
            got = absorb_byte(raw, r);
        end else if (in_frame && is_flag) begin
            r.kind = (nbytes >= 8'd2 && crc_acc == CRC_RESIDUE) ? KIND_GOOD : KIND_BAD;
            r.frame_length = (nbytes >= 8'd2) ? nbytes - 8'd2 : 8'd0;
            got = 1'b1;
            in_frame = 1'b0;
            nbytes = 8'd0;
        end
        after_flag = is_flag;
        return got;
    endfunction

    task automatic add_row(input logic [7:0] raw, input bit typed, input t_kind kind,
                           input logic [7:0] len);
        t_dir_row row;
        row.raw = raw;
        row.typed = typed;
        row.want = '0;
        row.want.kind = kind;
        row.want.frame_length = len;
        dir_rows.push_back(row);
    endtask

    task automatic push_byte(input logic [7:0] raw, input bit typed = 1'b0,
                             input t_result want = '0);
        t_result r;
        bit      got;
        while (!calm && $urandom_range(99) < 12) begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= raw;
        do @(posedge clk); while (!rx_ch.ready);
        if (en_reg) begin
            items_sent++;
        end
        got = predict_byte(raw, r);
        if (typed) begin
            pending_results.push_back(want);
        end else if (got) begin
            pending_results.push_back(r);
        end
    endtask

    task automatic write_enable(input logic v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.receive_enable <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        en_reg = v;
    endtask

    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic send_frame();
        logic [7:0]  body[$];
        logic [15:0] c;
        logic [7:0]  b;
        int          len;
        int          pick;
        int          r;
        int          idx;
        frame_no++;
        pick = $urandom_range(99);
        case (frame_no)
            8:       len = 125;
            20:      len = 126;
            32:      len = $urandom_range(127, 140);
            default: len = $urandom_range(0, 12);
        endcase
        if (len <= 12 && pick >= 85) begin
            // line noise
            repeat ($urandom_range(1, 10)) begin
                r = $urandom_range(99);
                b = (r < 25) ? FLAG_BYTE : (r < 40) ? ESC_BYTE : 8'($urandom_range(255));
                push_byte(b);
            end
            return;
        end
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            b = (r < 8) ? FLAG_BYTE : (r < 15) ? ESC_BYTE : 8'($urandom_range(255));
            body.push_back(b);
        end
        c = CRC_INIT;
        for (int i = 0; i < body.size(); i++) begin
            c = fcs_update(c, body[i]);
        end
        c = ~c;
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        if (pick >= 65 && pick < 80) begin
            if ($urandom_range(1)) begin
                idx = $urandom_range(body.size() - 1);
                body[idx] = body[idx] ^ (8'h01 << $urandom_range(7));
            end else begin
                void'(body.pop_back());
            end
        end
        if ($urandom_range(99) < 70) begin
            push_byte(FLAG_BYTE);
        end
        if ($urandom_range(99) < 10) begin
            push_byte(FLAG_BYTE);
        end
        for (int i = 0; i < body.size(); i++) begin
            r = $urandom_range(99);
            if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE || r < 8) begin
                if (r < 3) begin
                    push_byte(ESC_BYTE);
                end
                push_byte(ESC_BYTE);
                push_byte(body[i] ^ ESC_MASK);
            end else begin
                push_byte(body[i]);
            end
        end
        // dangling escape carries into the next frame
        if (pick >= 80 && pick < 85) begin
            push_byte(ESC_BYTE);
        end
        push_byte(FLAG_BYTE);
    endtask

    // result sink
    initial begin
        t_result exp_r;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result: kind %0d data %02h len %0d",
                                 res_ch.kind, res_ch.data_byte, res_ch.frame_length);
                    end
                end else begin
                    exp_r = pending_results.pop_front();
                    if (res_ch.kind !== exp_r.kind || res_ch.data_byte !== exp_r.data_byte
                        || res_ch.frame_length !== exp_r.frame_length) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: kind %0d/%0d data %02h/%02h len %0d/%0d",
                                     exp_r.kind, res_ch.kind, exp_r.data_byte,
                                     res_ch.data_byte, exp_r.frame_length,
                                     res_ch.frame_length);
                        end
                    end
                end
            end
            if (hold_ask) begin
                hold_ask = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'h00;
        cfg_ch.valid = 1'b0;
        cfg_ch.receive_enable = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_enable(1'b1);

        add_row(FLAG_BYTE, 1'b0, KIND_DATA, 8'd0);
        add_row(8'h00,     1'b0, KIND_DATA, 8'd0);
        add_row(FLAG_BYTE, 1'b1, KIND_BAD,  8'd0);   // one byte only
        add_row(FLAG_BYTE, 1'b0, KIND_DATA, 8'd0);
        add_row(ESC_BYTE,  1'b0, KIND_DATA, 8'd0);
        add_row(ESC_BYTE,  1'b0, KIND_DATA, 8'd0);   // repeated escape
        add_row(8'h5E,     1'b0, KIND_DATA, 8'd0);
        add_row(8'hFF,     1'b0, KIND_DATA, 8'd0);
        add_row(ESC_BYTE,  1'b0, KIND_DATA, 8'd0);   // pending across the flag
        add_row(FLAG_BYTE, 1'b0, KIND_DATA, 8'd0);
        add_row(8'h5D,     1'b0, KIND_DATA, 8'd0);
        add_row(FLAG_BYTE, 1'b1, KIND_BAD,  8'd0);
        for (int i = 1; i <= 9; i++) begin
            add_row(8'h30 + 8'(i), 1'b0, KIND_DATA, 8'd0);
        end
        add_row(8'h6E,     1'b0, KIND_DATA, 8'd0);
        add_row(8'h90,     1'b0, KIND_DATA, 8'd0);
        add_row(FLAG_BYTE, 1'b1, KIND_GOOD, 8'd9);
        for (int i = 0; i < dir_rows.size(); i++) begin
            push_byte(dir_rows[i].raw, dir_rows[i].typed, dir_rows[i].want);
        end
        settle();

        while (items_sent < 450) begin
            if (!hold_done && items_sent > 200) begin
                hold_ask = 1'b1;
                hold_done = 1'b1;
            end
            send_frame();
        end
        settle();

        write_enable(1'b0);
        repeat (40) push_byte(8'($urandom_range(255)));
        settle();
        write_enable(1'b1);

        calm = 1'b1;
        while (items_sent < 600) begin
            send_frame();
        end
        calm = 1'b0;
        while (items_sent < 710) begin
            send_frame();
        end
        rx_ch.valid <= 1'b0;

        for (int w = 0; w < 5000 && pending_results.size() != 0; w++) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            fail_count += pending_results.size();
        end
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
